FILE: rtl/swut_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swut_pkg
// Types and constants shared by the single-wire UART transceiver.
// ----------------------------------------------------------------------------
package swut_pkg;

  localparam int TICKS_W = 16;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 2;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_SEND = 2'd1,
    OP_RECV = 2'd2,
    OP_RSVD = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_TIMEOUT = 2'd1,
    ERR_PARITY  = 2'd2,
    ERR_FRAMING = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    PAR_NONE = 2'd0,
    PAR_EVEN = 2'd1,
    PAR_ODD  = 2'd2,
    PAR_RSVD = 2'd3
  } parity_t;

  typedef enum logic [IDX_W-1:0] {
    REG_BIT_TICKS   = 2'd0,
    REG_INVERT_LINE = 2'd1,
    REG_PARITY_MODE = 2'd2,
    REG_STOP_COUNT  = 2'd3
  } reg_idx_t;

  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_TX_BITS = 6'b000010,
    PH_TX_STOP = 6'b000100,
    PH_RX_HUNT = 6'b001000,
    PH_RX_BITS = 6'b010000,
    PH_RX_STOP = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [TICKS_W-1:0] bit_ticks;
    logic               invert_line;
    logic [1:0]         parity_mode;
    logic [1:0]         stop_count;
  } cfg_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] send_byte;
    logic       line_in;
  } in_item_t;

  typedef struct packed {
    logic       line_out;
    logic       line_drive;
    logic [7:0] recv_byte;
    logic       recv_valid;
    logic       send_done;
    logic [1:0] error_code;
    logic       busy_res;
  } out_item_t;

  // Handshake between the input holding register and the step stage.
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/swut_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swut_in_if / swut_out_if
// Valid/ready channels for tick words and result words.
// ----------------------------------------------------------------------------
interface swut_in_if;
  logic               valid;
  logic               ready;
  swut_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface swut_out_if;
  logic                valid;
  logic                ready;
  swut_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/swut_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swut_cfg_regs
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module swut_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        we,
  input  wire logic [swut_pkg::IDX_W-1:0]  index,
  input  wire logic [swut_pkg::CFG_W-1:0]  wdata,
  output swut_pkg::cfg_t                   cfg
);

  swut_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_ticks   <= swut_pkg::TICKS_W'(104);
      cfg_r.invert_line <= 1'b0;
      cfg_r.parity_mode <= swut_pkg::PAR_NONE;
      cfg_r.stop_count  <= 2'd1;
    end else if (we) begin
      unique case (swut_pkg::reg_idx_t'(index))
        swut_pkg::REG_BIT_TICKS:   cfg_r.bit_ticks   <= wdata[swut_pkg::TICKS_W-1:0];
        swut_pkg::REG_INVERT_LINE: cfg_r.invert_line <= wdata[0];
        swut_pkg::REG_PARITY_MODE: cfg_r.parity_mode <= wdata[1:0];
        swut_pkg::REG_STOP_COUNT:  cfg_r.stop_count  <= wdata[1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

FILE: rtl/swut_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swut_in_reg
// Input holding register; it refills in the same cycle it drains.
// ----------------------------------------------------------------------------
module swut_in_reg (
  input  wire logic               clk,
  input  wire logic               rst_n,
  swut_in_if.sink                 in_ch,
  input  wire logic               free,
  output swut_pkg::stage_ctl_t    ctl,
  output swut_pkg::in_item_t      item
);

  logic               valid_r;
  logic               valid_nxt;
  swut_pkg::in_item_t item_r;
  logic               advance;
  logic               take;

  assign advance     = valid_r && free;
  assign in_ch.ready = !valid_r || free;
  assign take        = in_ch.valid && in_ch.ready;
  assign valid_nxt   = take || (valid_r && !free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_ch.data;
    end
  end

  assign ctl.valid   = valid_r;
  assign ctl.advance = advance;
  assign item        = item_r;

endmodule
`default_nettype wire

FILE: rtl/swut_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swut_step
// One tick of the transceiver state machine, plus the result register.
// ----------------------------------------------------------------------------
module swut_step #(
  parameter int TIMEOUT_BITS = 30
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire swut_pkg::cfg_t        cfg,
  input  wire swut_pkg::stage_ctl_t  ctl,
  input  wire swut_pkg::in_item_t    item,
  output logic                       free,
  swut_out_if.source                 out_ch
);

  localparam int CNT_W  = swut_pkg::TICKS_W + $clog2(TIMEOUT_BITS + 1);
  localparam int NEED_W = swut_pkg::TICKS_W + 1;

  swut_pkg::phase_t    phase_r, phase_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [3:0]          bit_idx_r, bit_idx_nxt;
  logic [7:0]          shift_r, shift_nxt;
  logic [1:0]          stop_idx_r, stop_idx_nxt;
  swut_pkg::out_item_t res_r, res_nxt;
  logic                out_valid_r;

  logic [swut_pkg::TICKS_W-1:0] eff;
  logic [1:0]                   eff_stops;
  logic                         par_on;
  logic                         par_bit;
  logic                         logical;
  logic                         tx_bit;
  logic [NEED_W-1:0]            need;
  logic [CNT_W-1:0]             timeout_lim;

  assign eff       = (cfg.bit_ticks == '0) ? swut_pkg::TICKS_W'(1) : cfg.bit_ticks;
  assign eff_stops = cfg.stop_count[1] ? 2'd2 : 2'd1;
  assign par_on    = (cfg.parity_mode == swut_pkg::PAR_EVEN) ||
                     (cfg.parity_mode == swut_pkg::PAR_ODD);
  assign logical   = item.line_in ^ cfg.invert_line;
  assign timeout_lim = CNT_W'(TIMEOUT_BITS) * CNT_W'(eff);

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    bit_idx_nxt  = bit_idx_r;
    shift_nxt    = shift_r;
    stop_idx_nxt = stop_idx_r;
    tx_bit       = 1'b1;
    need         = NEED_W'(eff);
    par_bit      = 1'b0;

    res_nxt            = '0;
    res_nxt.line_out   = ~cfg.invert_line;
    res_nxt.error_code = swut_pkg::ERR_NONE;

    // A command in idle loads the state and is worked in the same tick.
    if (phase_r == swut_pkg::PH_IDLE) begin
      if (item.opcode == swut_pkg::OP_SEND) begin
        shift_nxt = item.send_byte;
        phase_nxt = swut_pkg::PH_TX_BITS;
        cnt_nxt = '0; bit_idx_nxt = '0; stop_idx_nxt = '0;
      end else if (item.opcode == swut_pkg::OP_RECV) begin
        shift_nxt = '0;
        phase_nxt = swut_pkg::PH_RX_HUNT;
        cnt_nxt = '0; bit_idx_nxt = '0; stop_idx_nxt = '0;
      end
    end

    par_bit = (^shift_nxt) ^ (cfg.parity_mode == swut_pkg::PAR_ODD);

    unique case (phase_nxt)
      swut_pkg::PH_IDLE: begin
      end
      swut_pkg::PH_TX_BITS, swut_pkg::PH_TX_STOP: begin
        if (phase_nxt == swut_pkg::PH_TX_STOP) tx_bit = 1'b1;
        else if (bit_idx_nxt == 4'd0) tx_bit = 1'b0;
        else if (bit_idx_nxt <= 4'd8) tx_bit = shift_nxt[3'(bit_idx_nxt - 4'd1)];
        else tx_bit = par_bit;
        res_nxt.line_out   = tx_bit ^ cfg.invert_line;
        res_nxt.line_drive = 1'b1;
        cnt_nxt = cnt_nxt + CNT_W'(1);
        if (cnt_nxt >= CNT_W'(eff)) begin
          cnt_nxt = '0;
          if (phase_nxt == swut_pkg::PH_TX_BITS) begin
            bit_idx_nxt = bit_idx_nxt + 4'd1;
            if ((bit_idx_nxt == 4'd9 && !par_on) || bit_idx_nxt >= 4'd10) begin
              phase_nxt    = swut_pkg::PH_TX_STOP;
              stop_idx_nxt = '0;
            end
          end else begin
            stop_idx_nxt = stop_idx_nxt + 2'd1;
            if (stop_idx_nxt >= eff_stops) begin
              res_nxt.send_done = 1'b1;
              phase_nxt         = swut_pkg::PH_IDLE;
            end
          end
        end
      end
      swut_pkg::PH_RX_HUNT: begin
        if (!logical) begin
          phase_nxt   = swut_pkg::PH_RX_BITS;
          cnt_nxt     = '0;
          bit_idx_nxt = '0;
        end else begin
          cnt_nxt = cnt_nxt + CNT_W'(1);
          if (cnt_nxt >= timeout_lim) begin
            res_nxt.error_code = swut_pkg::ERR_TIMEOUT;
            phase_nxt          = swut_pkg::PH_IDLE;
          end
        end
      end
      swut_pkg::PH_RX_BITS: begin
        // The first data bit is sampled one and a half bit times after the start edge.
        if (bit_idx_nxt == 4'd0) need = NEED_W'(eff) + NEED_W'(eff >> 1);
        cnt_nxt = cnt_nxt + CNT_W'(1);
        if (cnt_nxt >= CNT_W'(need)) begin
          cnt_nxt = '0;
          if (bit_idx_nxt < 4'd8) begin
            shift_nxt[bit_idx_nxt[2:0]] = logical;
            bit_idx_nxt = bit_idx_nxt + 4'd1;
            if (bit_idx_nxt == 4'd8 && !par_on) begin
              phase_nxt    = swut_pkg::PH_RX_STOP;
              stop_idx_nxt = '0;
            end
          end else if (logical != par_bit) begin
            res_nxt.error_code = swut_pkg::ERR_PARITY;
            phase_nxt          = swut_pkg::PH_IDLE;
          end else begin
            phase_nxt    = swut_pkg::PH_RX_STOP;
            stop_idx_nxt = '0;
          end
        end
      end
      swut_pkg::PH_RX_STOP: begin
        cnt_nxt = cnt_nxt + CNT_W'(1);
        if (cnt_nxt >= CNT_W'(eff)) begin
          cnt_nxt = '0;
          if (!logical) begin
            res_nxt.error_code = swut_pkg::ERR_FRAMING;
            phase_nxt          = swut_pkg::PH_IDLE;
          end else begin
            stop_idx_nxt = stop_idx_nxt + 2'd1;
            if (stop_idx_nxt >= eff_stops) begin
              res_nxt.recv_valid = 1'b1;
              res_nxt.recv_byte  = shift_nxt;
              phase_nxt          = swut_pkg::PH_IDLE;
            end
          end
        end
      end
      default: begin
        phase_nxt = swut_pkg::PH_IDLE;
      end
    endcase

    res_nxt.busy_res = (phase_nxt != swut_pkg::PH_IDLE);
  end

  assign free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= swut_pkg::PH_IDLE;
      cnt_r       <= '0;
      bit_idx_r   <= '0;
      shift_r     <= '0;
      stop_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.advance) begin
        phase_r    <= phase_nxt;
        cnt_r      <= cnt_nxt;
        bit_idx_r  <= bit_idx_nxt;
        shift_r    <= shift_nxt;
        stop_idx_r <= stop_idx_nxt;
      end
      if (ctl.advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance && ctl.valid) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = res_r;

endmodule
`default_nettype wire

FILE: rtl/single_wire_uart_transceiver_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// single_wire_uart_transceiver_top
// Half-duplex UART on one shared line, stepped by one tick word at a time.
// ----------------------------------------------------------------------------
// Each word on in_ch is one tick of the bit time base; its opcode may start a
// send or a receive. Every tick word yields exactly one result word on out_ch,
// carrying the line level and drive enable for that tick plus receive data,
// send completion, error code and busy status.
// Timing: a word goes through an input register and then a result register,
// after which its result is offered on out_ch. One word is accepted every
// cycle while out_ch does not stall; the tick step is a single pass of logic
// between those registers.
// If out_ch stalls, the result register holds its word, the input register
// keeps one more word, and in_ch.ready drops until the result is taken.
// Reset (rst_n low, synchronous) empties both registers, returns the state
// machine to idle and loads the default configuration: 104 ticks per bit,
// normal polarity, no parity, one stop bit. cfg_we writes register cfg_index
// with cfg_wdata; write only while no word is in flight.
// ----------------------------------------------------------------------------
module single_wire_uart_transceiver_top #(
  parameter int TIMEOUT_BITS = 30
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  swut_in_if.sink                          in_ch,
  swut_out_if.source                       out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [swut_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [swut_pkg::CFG_W-1:0]  cfg_wdata
);

  swut_pkg::cfg_t       cfg;
  swut_pkg::stage_ctl_t ctl;
  swut_pkg::in_item_t   item;
  logic                 free;

  swut_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  swut_in_reg u_in (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .free  (free),
    .ctl   (ctl),
    .item  (item)
  );

  swut_step #(
    .TIMEOUT_BITS (TIMEOUT_BITS)
  ) u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .ctl    (ctl),
    .item   (item),
    .free   (free),
    .out_ch (out_ch)
  );

  // With no result pending the block can always take a new word.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input not ready while result register is empty");

  // A good received byte never comes with an error or while driving the line.
  a_recv_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.recv_valid) |->
      (out_ch.data.error_code == swut_pkg::ERR_NONE && !out_ch.data.line_drive))
    else $error("received byte flagged with error or drive");

  // Send completion happens only on a driven tick and ends the activity.
  a_send_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.send_done) |->
      (out_ch.data.line_drive && !out_ch.data.busy_res))
    else $error("send_done without drive or with busy");

  // A word held in the input register drains once the result side is free.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.valid && free) |=> out_ch.valid)
    else $error("input word did not reach the result register");

endmodule
`default_nettype wire
